// ----- rtl/pfu_pkg.sv -----
// Shared types, constants and helpers for the profile factor update block.
// No dependencies; every other file in the block depends on this package.
`default_nettype none
package pfu_pkg;

  // Default sizes for the top-level parameters
  localparam int VEC_LEN_DEF   = 4;
  localparam int NUM_USERS_DEF = 256;
  localparam int NUM_ITEMS_DEF = 256;

  // Field widths fixed by the channel format
  localparam int ACT_W  = 3;
  localparam int IDX_W  = 8;
  localparam int DIM_W  = 2;
  localparam int DATA_W = 32;

  // Internal accumulator widths (sized for vectors of up to 16 elements)
  localparam int DOT_W  = 44;
  localparam int SQS_W  = 67;
  localparam int SAT_W  = 48;

  // Divider: |w| * 2^24 gives a 56-bit dividend, one quotient bit per step
  localparam int FRAC_W    = 24;
  localparam int DVD_W     = DATA_W + FRAC_W;
  localparam int DIV_CNT_W = 6;

  localparam logic signed [SAT_W-1:0] ONE_Q = SAT_W'(64'sd16777216);

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_LOAD_USER = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_ITEM = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ_USER = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ_ITEM = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD_U,
    OP_LOAD_I,
    OP_QUERY,
    OP_READ_U,
    OP_READ_I
  } pfu_op_t;

  // One classified command held in the queue
  typedef struct packed {
    pfu_op_t                  op;
    logic [IDX_W-1:0]         user_idx;
    logic [IDX_W-1:0]         item_idx;
    logic [DIM_W-1:0]         dim;
    logic signed [DATA_W-1:0] value;
  } pfu_cmd_t;

  // Queue head offered to the back end
  typedef struct packed {
    logic     valid;
    pfu_cmd_t cmd;
  } pfu_qhead_t;

  // Back end status returned to the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } pfu_bstat_t;

  typedef enum logic [4:0] {
    B_CLEAR,
    B_IDLE,
    B_Q_RD,
    B_Q_MUL,
    B_Q_ACC,
    B_Q_F,
    B_U_RD,
    B_U_MUL,
    B_U_WR,
    B_R_RD,
    B_R_W,
    B_R_SQ,
    B_R_ADD,
    B_SQ_INIT,
    B_SQRT,
    B_DIV_INIT,
    B_DIV,
    B_EMIT
  } pfu_bstate_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(64'sd2147483647);
    lo = SAT_W'(-64'sd2147483648);
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pfu_in_if.sv -----
// Input channel of the profile factor update block: handshake and command fields.
// Depends on pfu_pkg for field widths.
`default_nettype none
interface pfu_in_if;
  logic                           valid;
  logic                           ready;
  logic [pfu_pkg::ACT_W-1:0]      action;
  logic [pfu_pkg::IDX_W-1:0]      user_index;
  logic [pfu_pkg::IDX_W-1:0]      item_index;
  logic [pfu_pkg::DIM_W-1:0]      dim_index;
  logic signed [pfu_pkg::DATA_W-1:0] load_value;

  modport source(output valid, action, user_index, item_index, dim_index, load_value,
                 input ready);
  modport sink(input valid, action, user_index, item_index, dim_index, load_value,
               output ready);
endinterface
`default_nettype wire

// ----- rtl/pfu_out_if.sv -----
// Result channel of the profile factor update block: handshake and element fields.
// Depends on pfu_pkg for field widths.
`default_nettype none
interface pfu_out_if;
  logic                              valid;
  logic                              ready;
  logic [pfu_pkg::IDX_W-1:0]         entry_index;
  logic [pfu_pkg::DIM_W-1:0]         element_position;
  logic signed [pfu_pkg::DATA_W-1:0] element_value;
  logic                              zero_norm;
  logic                              last;

  modport source(output valid, entry_index, element_position, element_value, zero_norm,
                 last, input ready);
  modport sink(input valid, entry_index, element_position, element_value, zero_norm,
               last, output ready);
endinterface
`default_nettype wire

// ----- rtl/profile_factor_update_core.sv -----
// Profile factor update block: user and item profile tables with query-driven
// accumulator updates and normalised read-out.
//
// Input channel in_ch carries one command per transfer: load a user or item base
// element, query a user/item pair, or read out a user or item profile. Commands
// with an out-of-range index or position, and unknown actions, are taken and
// dropped. Accepted commands go into a two-entry queue; the back end runs them
// one at a time, so the queue keeps taking transfers while a command executes.
// A load writes its base table as it leaves the queue. A query runs one
// read/multiply/accumulate step per element, then one read/multiply/write
// step per element. A read sums the squares of the elements, runs the 32-step
// square root, then runs the bit-serial divider once per element. Results
// leave through out_ch, one element per transfer, with last on the final
// element; a held result register lets the divider carry on only once the
// receiver takes the previous element, so a stalled receiver stalls the
// read-out and then fills the queue.
// After reset the accumulators are zeroed by a clearing pass, during which
// in_ch.ready stays low.
// Depends on pfu_pkg, pfu_in_if, pfu_out_if, pfu_front and pfu_back.
`default_nettype none
module profile_factor_update_core #(
  parameter int VEC_LEN   = pfu_pkg::VEC_LEN_DEF,
  parameter int NUM_USERS = pfu_pkg::NUM_USERS_DEF,
  parameter int NUM_ITEMS = pfu_pkg::NUM_ITEMS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  pfu_in_if.sink    in_ch,
  pfu_out_if.source out_ch
);
  import pfu_pkg::*;

  pfu_qhead_t qhead;
  pfu_bstat_t bstat;

  // Accept and classify
  pfu_front #(
    .VEC_LEN   (VEC_LEN),
    .NUM_USERS (NUM_USERS),
    .NUM_ITEMS (NUM_ITEMS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .bstat (bstat),
    .qhead (qhead)
  );

  // Execute
  pfu_back #(
    .VEC_LEN   (VEC_LEN),
    .NUM_USERS (NUM_USERS),
    .NUM_ITEMS (NUM_ITEMS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qhead  (qhead),
    .bstat  (bstat),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/pfu_front.sv -----
// Front end: accepts input transfers, drops out-of-range and unknown commands, queues the rest.
// Depends on pfu_pkg and pfu_in_if.
`default_nettype none
module pfu_front #(
  parameter int VEC_LEN   = pfu_pkg::VEC_LEN_DEF,
  parameter int NUM_USERS = pfu_pkg::NUM_USERS_DEF,
  parameter int NUM_ITEMS = pfu_pkg::NUM_ITEMS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  pfu_in_if.sink              in_ch,
  input  pfu_pkg::pfu_bstat_t bstat,
  output pfu_pkg::pfu_qhead_t qhead
);
  import pfu_pkg::*;

  localparam int Q_DEPTH = 2;

  pfu_cmd_t   q_mem [Q_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  pfu_cmd_t cmd;
  logic     cmd_ok;
  logic     u_ok, v_ok, dim_ok;
  logic     push;
  logic     full;

  // Classify the offered command
  always_comb begin
    u_ok   = 32'(in_ch.user_index) < 32'(NUM_USERS);
    v_ok   = 32'(in_ch.item_index) < 32'(NUM_ITEMS);
    dim_ok = 32'(in_ch.dim_index) < 32'(VEC_LEN);
    cmd.user_idx = in_ch.user_index;
    cmd.item_idx = in_ch.item_index;
    cmd.dim      = in_ch.dim_index;
    cmd.value    = in_ch.load_value;
    case (in_ch.action)
      ACT_LOAD_USER: begin
        cmd.op = OP_LOAD_U;
        cmd_ok = u_ok && dim_ok;
      end
      ACT_LOAD_ITEM: begin
        cmd.op = OP_LOAD_I;
        cmd_ok = v_ok && dim_ok;
      end
      ACT_QUERY: begin
        cmd.op = OP_QUERY;
        cmd_ok = u_ok && v_ok;
      end
      ACT_READ_USER: begin
        cmd.op = OP_READ_U;
        cmd_ok = u_ok;
      end
      ACT_READ_ITEM: begin
        cmd.op = OP_READ_I;
        cmd_ok = v_ok;
      end
      default: begin
        cmd.op = OP_LOAD_U;
        cmd_ok = 1'b0;
      end
    endcase
  end

  // Queue control
  assign full        = cnt_r == 2'(Q_DEPTH);
  assign in_ch.ready = !full && !bstat.clearing;
  assign push        = in_ch.valid && in_ch.ready && cmd_ok;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = bstat.pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(bstat.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  assign qhead.valid = cnt_r != 2'd0;
  assign qhead.cmd   = q_mem[rd_ptr_r];

endmodule
`default_nettype wire

// ----- rtl/pfu_back.sv -----
// Back end: profile tables, query update sequencer, norm and division units, result register.
// Depends on pfu_pkg and pfu_out_if.
`default_nettype none
module pfu_back #(
  parameter int VEC_LEN   = pfu_pkg::VEC_LEN_DEF,
  parameter int NUM_USERS = pfu_pkg::NUM_USERS_DEF,
  parameter int NUM_ITEMS = pfu_pkg::NUM_ITEMS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  pfu_pkg::pfu_qhead_t qhead,
  output pfu_pkg::pfu_bstat_t bstat,
  pfu_out_if.source           out_ch
);
  import pfu_pkg::*;

  localparam int PW     = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int UROWS  = (NUM_USERS > 256) ? 256 : NUM_USERS;
  localparam int IROWS  = (NUM_ITEMS > 256) ? 256 : NUM_ITEMS;
  localparam int UIW    = (UROWS > 1) ? $clog2(UROWS) : 1;
  localparam int IIW    = (IROWS > 1) ? $clog2(IROWS) : 1;
  localparam int UAW    = UIW + PW;
  localparam int IAW    = IIW + PW;
  localparam int UDEPTH = 2 ** UAW;
  localparam int IDEPTH = 2 ** IAW;
  localparam int CLR_W  = (UAW > IAW) ? UAW : IAW;

  pfu_bstate_t state_r, state_nxt;

  // Tables
  logic signed [DATA_W-1:0] ub_mem [UDEPTH];
  logic signed [DATA_W-1:0] ib_mem [IDEPTH];
  logic signed [DATA_W-1:0] ua_mem [UDEPTH];
  logic signed [DATA_W-1:0] ia_mem [IDEPTH];
  logic signed [DATA_W-1:0] ub_q_r, ib_q_r, ua_q_r, ia_q_r;

  pfu_cmd_t          cur_r;
  logic [PW-1:0]     i_r;
  logic [CLR_W-1:0]  clr_cnt_r;
  logic              i_last;
  logic              clr_last;

  // Query datapath
  logic signed [63:0]       prod_r, pi_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [DATA_W-1:0] f_r;
  logic signed [DATA_W-1:0] ua_new, ia_new;

  // Read datapath
  logic signed [DATA_W-1:0] w_r [VEC_LEN];
  logic signed [DATA_W-1:0] w_new;
  logic [DATA_W-1:0]        m_r;
  logic [63:0]              sq_r;
  logic [SQS_W-1:0]         s_r;

  // Square root unit
  logic [63:0] sx_r, sres_r, sbit_r, strial;
  logic        scale_r;
  logic [32:0] norm;

  // Divider
  logic [DVD_W-1:0]     quo_r;
  logic [33:0]          rem_r, dtrial;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 neg_r;
  logic signed [DATA_W-1:0] w_sel;
  logic [DATA_W-1:0]    w_mag;
  logic signed [DATA_W-1:0] elem;

  // Output register
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic [DIM_W-1:0]         out_pos_r;
  logic signed [DATA_W-1:0] out_val_r;
  logic                     out_zn_r;
  logic                     out_last_r;
  logic                     slot_free;

  // Control strobes
  logic ub_we, ib_we, acc_we, base_re, acc_re, emit;
  logic [UAW-1:0] u_addr, ub_wa, ua_wa;
  logic [IAW-1:0] i_addr, ib_wa, ia_wa;
  logic signed [DATA_W-1:0] ua_wd, ia_wd;
  logic clr_u, clr_i;

  assign i_last    = i_r == PW'(VEC_LEN - 1);
  assign clr_last  = clr_cnt_r == {CLR_W{1'b1}};
  assign slot_free = !out_valid_r || out_ch.ready;
  assign norm      = scale_r ? {sres_r[31:0], 1'b0} : {1'b0, sres_r[31:0]};
  assign u_addr    = {UIW'(cur_r.user_idx), i_r};
  assign i_addr    = {IIW'(cur_r.item_idx), i_r};
  assign strial    = sres_r + sbit_r;
  assign dtrial    = {rem_r[32:0], quo_r[DVD_W-1]};
  assign w_sel     = w_r[i_r];
  assign w_mag     = w_sel[DATA_W-1] ? (~w_sel + 32'd1) : w_sel;

  // Accumulator updates and read-out sums
  always_comb begin
    ua_new = sat32(SAT_W'(ua_q_r) + SAT_W'($signed(prod_r[63:FRAC_W])));
    ia_new = sat32(SAT_W'(ia_q_r) + SAT_W'($signed(pi_r[63:FRAC_W])));
    if (cur_r.op == OP_READ_U) begin
      w_new = sat32(SAT_W'(ub_q_r) + SAT_W'(ua_q_r));
    end else begin
      w_new = sat32(SAT_W'(ib_q_r) + SAT_W'(ia_q_r));
    end
  end

  // Saturated signed quotient
  always_comb begin
    if (norm == 33'd0) begin
      elem = '0;
    end else if (!neg_r) begin
      elem = (quo_r > DVD_W'(32'h7fffffff)) ? 32'sh7fffffff : quo_r[DATA_W-1:0];
    end else begin
      elem = (quo_r > DVD_W'(32'h80000000)) ? 32'sh80000000 : (~quo_r[DATA_W-1:0] + 32'd1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR:    if (clr_last) state_nxt = B_IDLE;
      B_IDLE: begin
        if (qhead.valid) begin
          case (qhead.cmd.op)
            OP_QUERY:  state_nxt = B_Q_RD;
            OP_READ_U: state_nxt = B_R_RD;
            OP_READ_I: state_nxt = B_R_RD;
            default:   state_nxt = B_IDLE;
          endcase
        end
      end
      B_Q_RD:     state_nxt = B_Q_MUL;
      B_Q_MUL:    state_nxt = B_Q_ACC;
      B_Q_ACC:    state_nxt = i_last ? B_Q_F : B_Q_RD;
      B_Q_F:      state_nxt = B_U_RD;
      B_U_RD:     state_nxt = B_U_MUL;
      B_U_MUL:    state_nxt = B_U_WR;
      B_U_WR:     state_nxt = i_last ? B_IDLE : B_U_RD;
      B_R_RD:     state_nxt = B_R_W;
      B_R_W:      state_nxt = B_R_SQ;
      B_R_SQ:     state_nxt = B_R_ADD;
      B_R_ADD:    state_nxt = i_last ? B_SQ_INIT : B_R_RD;
      B_SQ_INIT:  state_nxt = B_SQRT;
      B_SQRT:     if (sbit_r == 64'd1) state_nxt = B_DIV_INIT;
      B_DIV_INIT: state_nxt = (norm == 33'd0) ? B_EMIT : B_DIV;
      B_DIV:      if (dcnt_r == DIV_CNT_W'(DVD_W - 1)) state_nxt = B_EMIT;
      B_EMIT:     if (slot_free) state_nxt = i_last ? B_IDLE : B_DIV_INIT;
      default:    state_nxt = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    bstat.pop      = (state_r == B_IDLE) && qhead.valid;
    bstat.clearing = state_r == B_CLEAR;
    ub_we   = bstat.pop && (qhead.cmd.op == OP_LOAD_U);
    ib_we   = bstat.pop && (qhead.cmd.op == OP_LOAD_I);
    acc_we  = (state_r == B_U_WR) || (state_r == B_CLEAR);
    base_re = (state_r == B_Q_RD) || (state_r == B_U_RD) || (state_r == B_R_RD);
    acc_re  = (state_r == B_U_RD) || (state_r == B_R_RD);
    emit    = (state_r == B_EMIT) && slot_free;
    ub_wa   = {UIW'(qhead.cmd.user_idx), PW'(qhead.cmd.dim)};
    ib_wa   = {IIW'(qhead.cmd.item_idx), PW'(qhead.cmd.dim)};
    clr_u   = (clr_cnt_r >> UAW) == '0;
    clr_i   = (clr_cnt_r >> IAW) == '0;
    if (state_r == B_CLEAR) begin
      ua_wa = UAW'(clr_cnt_r);
      ia_wa = IAW'(clr_cnt_r);
      ua_wd = '0;
      ia_wd = '0;
    end else begin
      ua_wa = u_addr;
      ia_wa = i_addr;
      ua_wd = ua_new;
      ia_wd = ia_new;
    end
  end

  // Table ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (ub_we) ub_mem[ub_wa] <= qhead.cmd.value;
    if (base_re) ub_q_r <= ub_mem[u_addr];
  end

  always_ff @(posedge clk) begin
    if (ib_we) ib_mem[ib_wa] <= qhead.cmd.value;
    if (base_re) ib_q_r <= ib_mem[i_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we && (state_r != B_CLEAR || clr_u)) ua_mem[ua_wa] <= ua_wd;
    if (acc_re) ua_q_r <= ua_mem[u_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we && (state_r != B_CLEAR || clr_i)) ia_mem[ia_wa] <= ia_wd;
    if (acc_re) ia_q_r <= ia_mem[i_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        cur_r <= qhead.cmd;
        i_r   <= '0;
        dot_r <= '0;
        s_r   <= '0;
      end
      B_Q_MUL: prod_r <= ub_q_r * ib_q_r;
      B_Q_ACC: begin
        dot_r <= dot_r + DOT_W'($signed(prod_r[63:FRAC_W]));
        i_r   <= i_r + PW'(1);
      end
      B_Q_F: begin
        f_r <= sat32(ONE_Q - SAT_W'(sat32(SAT_W'(dot_r))));
        i_r <= '0;
      end
      B_U_MUL: begin
        prod_r <= f_r * ib_q_r;
        pi_r   <= f_r * ub_q_r;
      end
      B_U_WR:  i_r <= i_r + PW'(1);
      B_R_W: begin
        w_r[i_r] <= w_new;
        m_r      <= w_new[DATA_W-1] ? (~w_new + 32'd1) : w_new;
      end
      B_R_SQ:  sq_r <= m_r * m_r;
      B_R_ADD: begin
        s_r <= s_r + SQS_W'(sq_r);
        i_r <= i_r + PW'(1);
      end
      B_SQ_INIT: begin
        scale_r <= s_r[SQS_W-1:64] != '0;
        sx_r    <= (s_r[SQS_W-1:64] == '0) ? s_r[63:0] : {s_r[65:64], s_r[63:2]};
        sres_r  <= '0;
        sbit_r  <= 64'd1 << 62;
        i_r     <= '0;
      end
      B_SQRT: begin
        if (sx_r >= strial) begin
          sx_r   <= sx_r - strial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      B_DIV_INIT: begin
        quo_r  <= {w_mag, FRAC_W'(0)};
        rem_r  <= '0;
        dcnt_r <= '0;
        neg_r  <= w_sel[DATA_W-1];
      end
      B_DIV: begin
        if (dtrial >= {1'b0, norm}) begin
          rem_r <= dtrial - {1'b0, norm};
          quo_r <= {quo_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= dtrial;
          quo_r <= {quo_r[DVD_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + DIV_CNT_W'(1);
      end
      B_EMIT: begin
        if (slot_free) i_r <= i_r + PW'(1);
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= (cur_r.op == OP_READ_U) ? cur_r.user_idx : cur_r.item_idx;
      out_pos_r  <= DIM_W'(i_r);
      out_val_r  <= elem;
      out_zn_r   <= norm == 33'd0;
      out_last_r <= i_last;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.entry_index      = out_idx_r;
  assign out_ch.element_position = out_pos_r;
  assign out_ch.element_value    = out_val_r;
  assign out_ch.zero_norm        = out_zn_r;
  assign out_ch.last             = out_last_r;

endmodule
`default_nettype wire
